>>> rtl/lse_pkg.sv
// Package for the LSB steganography embed/extract block.
// Holds payload and configuration types, register indexes and the parity helper.
// No dependencies.
`default_nettype none

package lse_pkg;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned CNT_W    = 17;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;
	localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

	// Group phase codes: pixel position within a three-pixel group
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRACT_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH = 2'd1;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic [PIX_W-1:0] text_byte;
		logic             start_of_image;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             char_valid;
		logic [PIX_W-1:0] char_out;
		logic             done_res;
	} pix_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic             extract_mode;
		logic [LEN_W-1:0] message_length;
	} cfg_t;

	// Force the channel's parity to the given bit; 255 steps down to 254
	function automatic logic [PIX_W-1:0] set_parity(input logic [PIX_W-1:0] ch,
	                                                 input logic bit_val);
		logic [PIX_W-1:0] res;
		res = ch;
		if (ch[0] != bit_val) begin
			if (ch == PIXEL_MAX) begin
				res = PIXEL_MAX - 8'd1;
			end else begin
				res = ch + 8'd1;
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lse_intf.sv
// Handshake interfaces for the pixel input, result output and configuration write channels.
// Depends on lse_pkg for the payload types.
`default_nettype none

interface lse_pix_in_if;
	logic              valid;
	logic              ready;
	lse_pkg::pix_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lse_pix_out_if;
	logic              valid;
	logic              ready;
	lse_pkg::pix_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lse_cfg_if;
	logic              valid;
	logic              ready;
	lse_pkg::cfg_wr_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/lse_core.sv
// Per-pixel embed/extract datapath with the stream state (phase, held byte, bits, count, done).
// Depends on lse_pkg.
`default_nettype none

module lse_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire lse_pkg::cfg_t     cfg,
	input  wire lse_pkg::pix_in_t  pix,
	output lse_pkg::pix_out_t      res
);

	logic [1:0]                   phase_q, phase_c, phase_n;
	logic [lse_pkg::PIX_W-1:0]    held_q, held_c, held_n;
	logic [5:0]                   acc_q, acc_c, acc_n;
	logic [lse_pkg::CNT_W-1:0]    cnt_q, cnt_c, cnt_n, cnt_inc;
	logic                         fin_q, fin_c, fin_n;
	logic [lse_pkg::PIX_W-1:0]    byte_sel;
	logic [2:0]                   bits;
	logic [lse_pkg::CNT_W-1:0]    len_ext, len_plus1;

	always_comb begin
		// start_of_image clears the stream before this pixel is handled
		phase_c = pix.start_of_image ? lse_pkg::PH_FIRST : phase_q;
		held_c  = pix.start_of_image ? '0 : held_q;
		acc_c   = pix.start_of_image ? '0 : acc_q;
		cnt_c   = pix.start_of_image ? '0 : cnt_q;
		fin_c   = pix.start_of_image ? 1'b0 : fin_q;

		len_ext   = {1'b0, cfg.message_length};
		len_plus1 = len_ext + 17'd1;
		cnt_inc   = (cnt_c == lse_pkg::COUNT_MAX) ? cnt_c : cnt_c + 17'd1;

		phase_n = phase_c;
		held_n  = held_c;
		acc_n   = acc_c;
		cnt_n   = cnt_c;
		fin_n   = fin_c;

		res.red_out    = pix.red_in;
		res.green_out  = pix.green_in;
		res.blue_out   = pix.blue_in;
		res.char_valid = 1'b0;
		res.char_out   = '0;

		byte_sel = (phase_c == lse_pkg::PH_FIRST) ? pix.text_byte : held_c;
		case (phase_c)
			lse_pkg::PH_FIRST:  bits = byte_sel[2:0];
			lse_pkg::PH_SECOND: bits = byte_sel[5:3];
			default:            bits = {1'b1, byte_sel[7:6]};
		endcase

		if (!cfg.extract_mode) begin
			// End test only at a group boundary: a started group is completed
			if (!fin_c && phase_c == lse_pkg::PH_FIRST && cnt_c >= len_ext) begin
				fin_n = 1'b1;
			end
			if (!fin_n) begin
				held_n        = byte_sel;
				res.red_out   = lse_pkg::set_parity(pix.red_in,   bits[0]);
				res.green_out = lse_pkg::set_parity(pix.green_in, bits[1]);
				res.blue_out  = lse_pkg::set_parity(pix.blue_in,  bits[2]);
				if (phase_c == lse_pkg::PH_FIRST || phase_c == lse_pkg::PH_SECOND) begin
					phase_n = phase_c + 2'd1;
				end else begin
					phase_n = lse_pkg::PH_FIRST;
					cnt_n   = cnt_inc;
					fin_n   = (cnt_inc >= len_ext);
				end
			end
		end else if (!fin_c) begin
			case (phase_c)
				lse_pkg::PH_FIRST: begin
					acc_n   = {3'b000, pix.blue_in[0], pix.green_in[0], pix.red_in[0]};
					phase_n = lse_pkg::PH_SECOND;
				end
				lse_pkg::PH_SECOND: begin
					acc_n   = acc_c | {pix.blue_in[0], pix.green_in[0], pix.red_in[0], 3'b000};
					phase_n = lse_pkg::PH_THIRD;
				end
				default: begin
					res.char_out   = {pix.green_in[0], pix.red_in[0], acc_c};
					res.char_valid = 1'b1;
					acc_n          = '0;
					phase_n        = lse_pkg::PH_FIRST;
					cnt_n          = cnt_inc;
					fin_n          = (cnt_inc >= len_plus1);
				end
			endcase
		end

		res.done_res = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lse_pkg::PH_FIRST;
			held_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			held_q  <= held_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			fin_q   <= fin_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lsb_stego_embed_extract.sv
// Top level of the LSB steganography embed/extract block: config registers and output register.
// Depends on lse_pkg, lse_intf.sv and lse_core.
//
//  channel   | direction | payload                                        | transfer when
//  pix_in    | in        | red/green/blue_in, text_byte, start_of_image   | valid && ready
//  pix_out   | out       | red/green/blue_out, char_valid/out, done_res   | valid && ready
//  cfg       | in        | index (0 extract_mode, 1 message_length), data | valid && ready
//
// One pixel per cycle unless pix_out stalls; each result appears in the cycle after its
// input transfer, from a single output register fed by the parity-adjust logic in lse_core.
// pix_in is ready whenever the output register is empty or being drained that cycle.
// Reset clears the stream state, both config registers and the output valid flag.
// cfg is always ready; writes to unknown indexes are ignored.
`default_nettype none

module lsb_stego_embed_extract (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lse_pix_in_if.sink    pix_in,
	lse_pix_out_if.source pix_out,
	lse_cfg_if.sink       cfg
);

	lse_pkg::cfg_t     cfg_q;
	lse_pkg::pix_out_t res_c;
	lse_pkg::pix_out_t res_q;
	logic              res_valid_q;
	logic              take;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = !res_valid_q || pix_out.ready;
	assign take         = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extract_mode   <= 1'b0;
			cfg_q.message_length <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				lse_pkg::CFG_EXTRACT_MODE:   cfg_q.extract_mode   <= cfg.data.data[0];
				lse_pkg::CFG_MESSAGE_LENGTH: cfg_q.message_length <= cfg.data.data[lse_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	lse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (take),
		.cfg    (cfg_q),
		.pix    (pix_in.data),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			// drop the result once it has been taken
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_c;
		end
	end

	assign pix_out.valid = res_valid_q;
	assign pix_out.data  = res_q;

endmodule

`default_nettype wire

>>> verif/lsb_stego_embed_extract_tb.sv
// Self-checking testbench for lsb_stego_embed_extract: directed table, then random images.
// Predicts every pixel result in a local model of the embed/extract state and checks in order.
// Depends on lse_pkg, lse_intf.sv and the RTL top level.

module lsb_stego_embed_extract_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lse_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 63;
	localparam int DIR_COUNT   = 23;

	typedef struct packed {
		logic             reconfig;
		logic             mode;
		logic [LEN_W-1:0] len;
		pix_in_t          px;
		logic             typed;
		pix_out_t         want;
	} stim_row_t;

	localparam pix_out_t NO_WANT = '0;

	// Rows with typed results are read straight off the rules; the rest go to the predictor.
	localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
		// embed, empty message: finished on the first pixel
		'{1'b1, 1'b0, 16'h0000, '{8'hFF, 8'h00, 8'h80, 8'hA5, 1'b1},
			1'b1, '{8'hFF, 8'h00, 8'h80, 1'b0, 8'h00, 1'b1}},
		'{1'b0, 1'b0, 16'h0000, '{8'h01, 8'h02, 8'h03, 8'h00, 1'b0},
			1'b1, '{8'h01, 8'h02, 8'h03, 1'b0, 8'h00, 1'b1}},
		// embed one zero byte: 255 steps down, blue of the third pixel forced odd
		'{1'b1, 1'b0, 16'h0001, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1},
			1'b1, '{8'hFE, 8'hFE, 8'hFE, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b0, 16'h0001, '{8'h00, 8'h01, 8'hFE, 8'hFF, 1'b0},
			1'b1, '{8'h00, 8'h02, 8'hFE, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b0, 16'h0001, '{8'hFF, 8'h00, 8'h00, 8'h00, 1'b0},
			1'b1, '{8'hFE, 8'h00, 8'h01, 1'b0, 8'h00, 1'b1}},
		'{1'b0, 1'b0, 16'h0001, '{8'h07, 8'h07, 8'h07, 8'h3C, 1'b0},
			1'b1, '{8'h07, 8'h07, 8'h07, 1'b0, 8'h00, 1'b1}},
		// embed 0xFF then a second byte
		'{1'b1, 1'b0, 16'h0002, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1},
			1'b1, '{8'h01, 8'h01, 8'h01, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b0, 16'h0002, '{8'hFF, 8'hFE, 8'h00, 8'h00, 1'b0},
			1'b1, '{8'hFF, 8'hFF, 8'h01, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b0, 16'h0002, '{8'h80, 8'h40, 8'hFF, 8'h00, 1'b0},
			1'b1, '{8'h81, 8'h41, 8'hFF, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b0, 16'h0002, '{8'h3A, 8'hC5, 8'h80, 8'h5A, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, 1'b0, 16'h0002, '{8'h11, 8'h22, 8'h33, 8'h00, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, 1'b0, 16'h0002, '{8'hFE, 8'h01, 8'h7F, 8'h00, 1'b0}, 1'b0, NO_WANT},
		// extract, empty message: still one byte comes out
		'{1'b1, 1'b1, 16'h0000, '{8'h01, 8'h00, 8'h01, 8'hFF, 1'b1},
			1'b1, '{8'h01, 8'h00, 8'h01, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b1, 16'h0000, '{8'h00, 8'h01, 8'h00, 8'h00, 1'b0},
			1'b1, '{8'h00, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0}},
		'{1'b0, 1'b1, 16'h0000, '{8'h01, 8'h01, 8'h00, 8'h00, 1'b0},
			1'b1, '{8'h01, 8'h01, 8'h00, 1'b1, 8'hD5, 1'b1}},
		'{1'b0, 1'b1, 16'h0000, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0},
			1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b1}},
		// extract, longest message, then switch to embed part way through a group
		'{1'b1, 1'b1, 16'hFFFF, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, 1'b1, 16'hFFFF, '{8'hFE, 8'hFE, 8'hFE, 8'h00, 1'b0}, 1'b0, NO_WANT},
		'{1'b1, 1'b0, 16'hFFFF, '{8'h80, 8'h81, 8'h82, 8'h99, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, 1'b0, 16'hFFFF, '{8'h55, 8'hAA, 8'hFF, 8'hC3, 1'b0}, 1'b0, NO_WANT},
		'{1'b0, 1'b0, 16'hFFFF, '{8'h00, 8'hFF, 8'h00, 8'h0F, 1'b0}, 1'b0, NO_WANT},
		// start of image part way through a group
		'{1'b0, 1'b0, 16'hFFFF, '{8'h40, 8'h41, 8'h42, 8'hE7, 1'b1}, 1'b0, NO_WANT},
		'{1'b0, 1'b0, 16'hFFFF, '{8'hFF, 8'h00, 8'hFF, 8'h81, 1'b0}, 1'b0, NO_WANT}
	};

	logic clk;
	logic arst_n;

	lse_pix_in_if  pix_in ();
	lse_pix_out_if pix_out ();
	lse_cfg_if     cfg ();

	lsb_stego_embed_extract uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	// Local copy of the configuration and stream state
	logic             cfg_extract = 1'b0;
	logic [LEN_W-1:0] cfg_len     = '0;
	logic [1:0]       grp_phase   = PH_FIRST;
	logic [7:0]       grp_byte    = '0;
	logic [5:0]       lsb_acc     = '0;
	logic [CNT_W-1:0] byte_tally  = '0;
	logic             msg_done    = 1'b0;

	pix_out_t pending_pixels [$];
	int       mismatch_count = 0;
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;
	int       hold_left      = 0;
	bit       hold_request   = 1'b0;
	int       cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] force_parity(input logic [7:0] chan, input logic want_bit);
		if (chan[0] == want_bit)
			return chan;
		return (chan == 8'hFF) ? 8'hFE : chan + 8'd1;
	endfunction

	// Advance the local state by one pixel and return its result
	function automatic pix_out_t stego_predict(input pix_in_t px);
		pix_out_t res;
		int       shift;
		res = '0;
		res.red_out   = px.red_in;
		res.green_out = px.green_in;
		res.blue_out  = px.blue_in;
		if (px.start_of_image) begin
			grp_phase  = PH_FIRST;
			grp_byte   = '0;
			lsb_acc    = '0;
			byte_tally = '0;
			msg_done   = 1'b0;
		end
		if (!cfg_extract) begin
			// end of message is only noticed at the head of a group
			if (!msg_done && grp_phase == PH_FIRST && byte_tally >= {1'b0, cfg_len})
				msg_done = 1'b1;
			if (!msg_done) begin
				if (grp_phase == PH_FIRST)
					grp_byte = px.text_byte;
				shift = 3 * int'(grp_phase);
				res.red_out   = force_parity(px.red_in, grp_byte[shift]);
				res.green_out = force_parity(px.green_in, grp_byte[shift + 1]);
				if (grp_phase < PH_THIRD) begin
					res.blue_out = force_parity(px.blue_in, grp_byte[shift + 2]);
					grp_phase    = grp_phase + 2'd1;
				end else begin
					res.blue_out = force_parity(px.blue_in, 1'b1);
					grp_phase    = PH_FIRST;
					if (byte_tally != COUNT_MAX)
						byte_tally = byte_tally + 1'b1;
					if (byte_tally >= {1'b0, cfg_len})
						msg_done = 1'b1;
				end
			end
		end else if (!msg_done) begin
			case (grp_phase)
				PH_FIRST: begin
					lsb_acc   = {3'b000, px.blue_in[0], px.green_in[0], px.red_in[0]};
					grp_phase = PH_SECOND;
				end
				PH_SECOND: begin
					// merge into whatever the accumulator already holds
					lsb_acc   = lsb_acc | {px.blue_in[0], px.green_in[0], px.red_in[0], 3'b000};
					grp_phase = PH_THIRD;
				end
				default: begin
					res.char_valid = 1'b1;
					res.char_out   = {px.green_in[0], px.red_in[0], lsb_acc};
					grp_phase      = PH_FIRST;
					lsb_acc        = '0;
					if (byte_tally != COUNT_MAX)
						byte_tally = byte_tally + 1'b1;
					if (byte_tally >= {1'b0, cfg_len} + 17'd1)
						msg_done = 1'b1;
				end
			endcase
		end
		res.done_res = msg_done;
		return res;
	endfunction

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'hFE;
			3: return 8'h01;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(input pix_in_t px, input logic typed, input pix_out_t want);
		pix_out_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data  <= px;
		do @(posedge clk); while (!pix_in.ready);
		predicted = stego_predict(px);
		pending_pixels.push_back(typed ? want : predicted);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		pix_in.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_config(input logic mode, input logic [LEN_W-1:0] len);
		cfg_wr_t wr;
		wr.index = CFG_EXTRACT_MODE;
		wr.data  = {15'd0, mode};
		cfg.valid <= 1'b1;
		cfg.data  <= wr;
		do @(posedge clk); while (!cfg.ready);
		cfg_extract = mode;
		wr.index = CFG_MESSAGE_LENGTH;
		wr.data  = len;
		cfg.data <= wr;
		do @(posedge clk); while (!cfg.ready);
		cfg_len = len;
		cfg.valid <= 1'b0;
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
	                             input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				pix_out.ready <= 1'b0;
				hold_left--;
			end else begin
				pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got %h", $time,
				         pix_out.data);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				compare_field("red_out", want.red_out, pix_out.data.red_out);
				compare_field("green_out", want.green_out, pix_out.data.green_out);
				compare_field("blue_out", want.blue_out, pix_out.data.blue_out);
				compare_field("char_valid", 8'(want.char_valid), 8'(pix_out.data.char_valid));
				compare_field("char_out", want.char_out, pix_out.data.char_out);
				compare_field("done_res", 8'(want.done_res), 8'(pix_out.data.done_res));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		pix_in_t    px;
		logic       mode;
		logic [15:0] len;
		arst_n       <= 1'b0;
		pix_in.valid <= 1'b0;
		pix_in.data  <= '0;
		cfg.valid    <= 1'b0;
		cfg.data     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].reconfig) begin
				drain_results();
				set_config(DIR_ROWS[i].mode, DIR_ROWS[i].len);
			end
			send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case ((p / 2) % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			mode = p[0];
			case (p)
				0, 3:    len = 16'h0000;
				1, 2:    len = 16'hFFFF;
				default: len = 16'($urandom_range(10, 1));
			endcase
			set_config(mode, len);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the output long enough for the input to back up
				if (p == 8 && n == 20)
					hold_request = 1'b1;
				if (p == 6 && n == 30)
					drain_results();
				px.red_in         = pick_channel();
				px.green_in       = pick_channel();
				px.blue_in        = pick_channel();
				px.text_byte      = 8'($urandom_range(255));
				px.start_of_image = (n == 0) || ($urandom_range(29) == 0);
				send_pixel(px, 1'b0, NO_WANT);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
